// File: hdl/lis_length_stream_unit_defines.svh
// ---------------------------------------------------------------------------
// LIS length stream unit: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LIS_LENGTH_STREAM_UNIT_DEFINES_SVH
`define LIS_LENGTH_STREAM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lis_length_stream_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lis_length_stream_unit: next-cycle check failed");

`endif

// File: hdl/lis_pkg.sv
// ---------------------------------------------------------------------------
// LIS length stream package
// Result layout and control codes shared by the LIS length stream unit.
// ---------------------------------------------------------------------------
package lis_pkg;

  // Width of the reported length field.
  localparam int LIS_W = 11;

  // Width of the result tdata: length and overflow flag, padded to bytes.
  localparam int OUT_TW = 16;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic [OUT_TW-LIS_W-2:0] pad;
    logic                    overflow;
    logic [LIS_W-1:0]        lis_length;
  } out_beat_t;

endpackage

// File: hdl/lis_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ---------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lis_length_stream_unit.sv
// ---------------------------------------------------------------------------
// LIS length stream unit
// Streaming length of the longest strictly increasing subsequence.
// ---------------------------------------------------------------------------
// Each input transaction carries one signed value (low DATA_WIDTH bits of
// s_tdata) and, in s_tuser, a flag that starts a new sequence. Each input
// transaction yields exactly one output transaction with the current length
// and an overflow flag. The smallest end value of each run length lives in a
// RAM of MAX_LEN entries; the first and last valid entries are mirrored in
// registers. An item that starts a sequence, lowers the first entry, extends
// the longest run, equals the only entry or is dropped on a full store goes
// straight to the result state. Any other item runs a binary search that
// reads the RAM once per cycle. The RAM needs no clearing after reset. A new
// item is taken while the previous result still waits on the output register.
// ---------------------------------------------------------------------------
`include "lis_length_stream_unit_defines.svh"

module lis_length_stream_unit
  import lis_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // value (DATA_WIDTH bits, signed), zero padding to whole bytes
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
  // first
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // lis_length (11 bits), overflow (1 bit), zero padding
  output logic [OUT_TW-1:0]                   m_tdata
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [1:0]                   state, state_next;
  logic [LW-1:0]                len, len_next;
  logic signed [DATA_WIDTH-1:0] head, head_next;
  logic signed [DATA_WIDTH-1:0] last, last_next;
  logic signed [DATA_WIDTH-1:0] val, val_next;
  logic [AW-1:0]                lo, lo_next;
  logic [AW-1:0]                hi, hi_next;
  logic [AW-1:0]                mid, mid_next;
  logic                         ovf, ovf_next;
  logic                         out_valid, out_valid_next;
  out_beat_t                    out_beat, out_beat_next;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [DATA_WIDTH-1:0]        wdata;
  logic [AW-1:0]                raddr;
  logic [DATA_WIDTH-1:0]        rdata;

  logic signed [DATA_WIDTH-1:0] in_val;
  logic [LW-1:0]                len_m1;
  logic [LW+LIS_W-1:0]          len_wide;
  logic                         ge;
  logic [AW-1:0]                lo_n, hi_n;

  lis_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_tail_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_val   = $signed(s_tdata[DATA_WIDTH-1:0]);
  assign len_m1   = len - LW'(1);
  assign len_wide = {{LIS_W{1'b0}}, len};
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_beat;

  // One search step: rdata holds the entry at mid, read in the previous cycle.
  assign ge   = ($signed(rdata) >= val);
  assign lo_n = ge ? lo : mid + AW'(1);
  assign hi_n = ge ? mid : hi;

  always_comb begin
    state_next     = state;
    len_next       = len;
    head_next      = head;
    last_next      = last;
    val_next       = val;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    ovf_next       = ovf;
    out_valid_next = out_valid && !m_tready;
    out_beat_next  = out_beat;
    we             = 1'b0;
    waddr          = '0;
    wdata          = val;
    raddr          = mid;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          val_next   = in_val;
          ovf_next   = 1'b0;
          state_next = ST_DONE;
          if (s_tuser || len == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_val;
            len_next  = LW'(1);
            head_next = in_val;
            last_next = in_val;
          end else if (in_val < head) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_val;
            head_next = in_val;
            if (len == LW'(1)) begin
              last_next = in_val;
            end
          end else if (in_val > last) begin
            if (len < LW'(MAX_LEN)) begin
              we        = 1'b1;
              waddr     = len[AW-1:0];
              wdata     = in_val;
              last_next = in_val;
              len_next  = len + LW'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end else if (len != LW'(1)) begin
            // The value lies between the first and last entries: search.
            lo_next    = '0;
            hi_next    = len_m1[AW-1:0];
            mid_next   = len_m1[AW-1:0] >> 1;
            raddr      = len_m1[AW-1:0] >> 1;
            state_next = ST_SRCH;
          end
        end
      end

      ST_SRCH: begin
        if (lo_n == hi_n) begin
          we         = 1'b1;
          waddr      = lo_n;
          wdata      = val;
          state_next = ST_DONE;
          if (lo_n == '0) begin
            head_next = val;
          end
          if (lo_n == len_m1[AW-1:0]) begin
            last_next = val;
          end
        end else begin
          lo_next  = lo_n;
          hi_next  = hi_n;
          mid_next = lo_n + ((hi_n - lo_n) >> 1);
          raddr    = lo_n + ((hi_n - lo_n) >> 1);
        end
      end

      ST_DONE: begin
        if (!out_valid || m_tready) begin
          out_valid_next           = 1'b1;
          out_beat_next.pad        = '0;
          out_beat_next.overflow   = ovf;
          out_beat_next.lis_length = len_wide[LIS_W-1:0];
          state_next               = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      out_valid <= out_valid_next;
    end
    head     <= head_next;
    last     <= last_next;
    val      <= val_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    ovf      <= ovf_next;
    out_beat <= out_beat_next;
  end

  `LIS_ASSERT_SAME(a_len_range, 1'b1, len <= LW'(MAX_LEN))
  `LIS_ASSERT_SAME(a_srch_interval, state == ST_SRCH, lo < hi)
  `LIS_ASSERT_SAME(a_srch_bound, state == ST_SRCH, LW'(hi) < len)
  `LIS_ASSERT_NEXT(a_first_restarts, s_tvalid && s_tready && s_tuser, len == LW'(1))

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// LIS length stream unit regression bench
// Drives signed values through the stream input and checks every output
// transaction against a patience-method tracker kept in the bench, or against the typed row's values.
// ---------------------------------------------------------------------------
// A short directed table covers the field extremes, equal values, restarts
// and lowering of the first tail entry. Random sequences then run under
// several idling patterns, and one long rising run builds a deep tail store
// so that searches over many entries are exercised.
// ---------------------------------------------------------------------------
module tb_top
  import lis_pkg::*;
();

  localparam int MAX_LEN     = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_DIRECTED  = 20;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [31:0]      value;
    logic             first;
    logic             typed;
    logic [LIS_W-1:0] exp_len;
    logic             exp_ovf;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_TW-1:0] m_tdata;

  // Tracker state: smallest end value of each run length, and valid count.
  logic signed [DATA_WIDTH-1:0] tail_ends [MAX_LEN];
  int                           run_len = 0;

  out_beat_t pending_lengths [$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0005, 1'b0, 1'b1, 11'd1, 1'b0},  // empty store after reset
    '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},  // most negative lowers the first entry
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},  // most positive extends
    '{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b1, 11'd1, 1'b0},  // restart
    '{32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},  // equal to the only entry
    '{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h8000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h7FFF_FFFE, 1'b1, 1'b1, 11'd1, 1'b0}
  };

  lis_length_stream_unit #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Updates the tail store with one value and returns the length it reports.
  function automatic out_beat_t lis_track(input logic [31:0] raw, input logic first);
    logic signed [DATA_WIDTH-1:0] v;
    int                           lo;
    int                           hi;
    int                           mid;
    out_beat_t                    beat;
    v    = raw;
    beat = '0;
    if (first) run_len = 0;
    if (run_len == 0) begin
      tail_ends[0] = v;
      run_len      = 1;
    end else if (v < tail_ends[0]) begin
      tail_ends[0] = v;
    end else if (v > tail_ends[run_len-1]) begin
      if (run_len < MAX_LEN) begin
        tail_ends[run_len] = v;
        run_len++;
      end else begin
        beat.overflow = 1'b1;
      end
    end else begin
      // The last entry is known to be >= v, so the search always lands.
      lo = 0;
      hi = run_len - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tail_ends[mid] >= v) hi = mid;
        else lo = mid + 1;
      end
      tail_ends[lo] = v;
    end
    beat.lis_length = LIS_W'(run_len);
    return beat;
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 31 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 31 : 0;
  endtask

  // Called at a rising edge; returns at the rising edge that takes the transaction.
  task automatic send_value(input logic [31:0] v, input logic f,
                            input logic typed = 1'b0, input out_beat_t typed_beat = '0);
    out_beat_t beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= f;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    beat = lis_track(v, f);
    pending_lengths = {pending_lengths, (typed ? typed_beat : beat)};
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_lengths.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] noise_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = 32'($urandom_range(0, 16)) - 32'd8;
      2: v = 32'h7FFF_FFFF - 32'($urandom_range(0, 4));
      default: v = 32'h8000_0000 + 32'($urandom_range(0, 4));
    endcase
    return v;
  endfunction

  // Mostly rising sequences with jitter and repeats, the rest noise.
  task automatic random_traffic(input int n_items);
    int          sent;
    int          seq_len;
    int          step;
    int          i;
    logic        wellformed;
    logic        f;
    logic [31:0] base;
    logic [31:0] v;
    logic [31:0] prev;
    sent = 0;
    prev = '0;
    while (sent < n_items) begin
      seq_len    = $urandom_range(1, 40);
      wellformed = ($urandom_range(0, 99) < 75);
      base       = $urandom;
      step       = $urandom_range(1, 64);
      for (i = 0; i < seq_len && sent < n_items; i++) begin
        if (wellformed) begin
          v = base + 32'(i * step);
          if ($urandom_range(0, 9) < 3) v = v - 32'($urandom_range(0, 8 * step));
          else if ($urandom_range(0, 9) == 0) v = prev;
          f = (i == 0) ? ($urandom_range(0, 99) < 90) : 1'b0;
        end else begin
          v = noise_value();
          f = (i == 0) ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 5);
        end
        send_value(v, f);
        prev = v;
        sent++;
      end
    end
  endtask

  // One long rising run up to a given length, then mixed items that may lengthen it further.
  task automatic long_run(input int target_len);
    int          i;
    logic [31:0] top;
    logic [31:0] v;
    top = 32'hFFF0_0000;
    send_value(top, 1'b1);
    while (run_len < target_len) begin
      if ($urandom_range(0, 7) == 0) begin
        v = top - 32'($urandom_range(0, 40000));
      end else begin
        top = top + 32'($urandom_range(1, 64));
        v   = top;
      end
      send_value(v, 1'b0);
    end
    for (i = 0; i < 20; i++) begin
      case ($urandom_range(0, 3))
        0: v = top + 32'($urandom_range(1, 1000));
        1: v = 32'h7FFF_FFFF;
        2: v = top - 32'($urandom_range(0, 70000));
        default: v = 32'h8000_0000;
      endcase
      send_value(v, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Outputs are sampled at the falling edge, where they are settled.
  always @(negedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("lis_length_stream_unit regression: fail");
          $finish;
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_lengths.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: lis_length %0d overflow %0b",
                     got.lis_length, got.overflow);
        end else begin
          want = pending_lengths.pop_front();
          if (got.lis_length !== want.lis_length || got.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected lis_length %0d overflow %0b, got %0d %0b",
                       want.lis_length, want.overflow, got.lis_length, got.overflow);
          end
        end
      end
    end
  end

  initial begin
    out_beat_t typed_beat;
    int        r;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    for (r = 0; r < N_DIRECTED; r++) begin
      typed_beat            = '0;
      typed_beat.lis_length = directed_rows[r].exp_len;
      typed_beat.overflow   = directed_rows[r].exp_ovf;
      send_value(directed_rows[r].value, directed_rows[r].first,
                 directed_rows[r].typed, typed_beat);
    end

    // Each phase but the last starts from an empty pipeline.
    wait_drained();
    set_idling(IDLE_SEND);
    random_traffic(110);
    wait_drained();
    set_idling(IDLE_RECV);
    random_traffic(110);
    wait_drained();
    set_idling(IDLE_BOTH);
    random_traffic(110);
    wait_drained();
    set_idling(IDLE_NONE);
    random_traffic(110);
    wait_drained();
    set_idling(IDLE_SEND);
    long_run(96);
    set_idling(IDLE_BOTH);
    random_traffic(30);

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_lengths.size() == 0) begin
      $display("lis_length_stream_unit regression: pass");
    end else begin
      $display("lis_length_stream_unit regression: fail");
    end
    $finish;
  end

endmodule
